// ===== hw/rtl/circular_deque_assert.svh =====
// Assertion macros used by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular_deque: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular_deque: next-cycle check failed");

`endif

// ===== hw/rtl/cdq_pkg.sv =====
// Package: types, command and status codes for the circular deque.
`timescale 1ns / 1ps
package cdq_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefDataWidth = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

endpackage

// ===== hw/rtl/circular_deque.sv =====
// Push, full and empty answers go into the output register on the transfer. Pop answers pass the
// memory read register, then the output register; a dump sends its entries the same way, 1 entry
// per cycle while the output drains. Pushes: one per cycle while the output drains. Pop and dump
// hold off new commands until their last result leaves, set by the entry memory's single read port.
// Reset: asynchronous, active low; pointers and occupancy clear, queue empty, memory not cleared.
`timescale 1ns / 1ps
`include "circular_deque_assert.svh"
module circular_deque import cdq_pkg::*; #(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // Ring pointer helpers, wrap at any depth (not only powers of two).
  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrMax) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_prev(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrMax : p - PtrW'(1);
  endfunction

  // Control state
  state_e          state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;    // front entry
  logic [PtrW-1:0] tail_q, tail_d;    // slot after the back entry
  logic [CntW-1:0] occ_q, occ_d;      // stored entries
  logic [CntW-1:0] cnt_q, cnt_d;      // results still to send from the read path
  logic [PtrW-1:0] rptr_q, rptr_d;    // next dump read address

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_load;

  // Entry memory, one write and one read port, registered read data
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  mem_we;
  logic [PtrW-1:0]       mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [PtrW-1:0]       mem_raddr;

  logic in_fire;
  logic out_free;
  logic q_empty;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign q_empty  = (occ_q == '0);

  // Next state: a pop or dump on a non-empty queue goes through the read path.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !q_empty &&
            (in_data_i.cmd inside {CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP})) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // last read result leaves once the output register is free
        if (out_free && (cnt_q == CntOne)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and handshake control
  always_comb begin
    in_ready_o = 1'b0;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    cnt_d      = cnt_q;
    rptr_d     = rptr_q;
    out_load   = 1'b0;
    out_d      = out_q;
    mem_we     = 1'b0;
    mem_waddr  = tail_q;
    mem_wdata  = DATA_WIDTH'($signed(in_data_i.data_in));
    mem_re     = 1'b0;
    mem_raddr  = head_q;

    case (state_q)
      ST_IDLE: begin
        // the output register is empty or drains at this edge
        in_ready_o = out_free;
        if (in_fire) begin
          case (in_data_i.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_load = 1'b1;
              out_d    = '{data_out: '0, status: STAT_OK, last: 1'b1};
              if (occ_q == CntFull) begin
                out_d.status = STAT_FULL;   // dropped
              end else begin
                mem_we = 1'b1;
                occ_d  = occ_q + CntOne;
                if (in_data_i.cmd == CMD_PUSH_FRONT) begin
                  head_d    = ptr_prev(head_q);
                  mem_waddr = ptr_prev(head_q);
                end else begin
                  mem_waddr = tail_q;
                  tail_d    = ptr_next(tail_q);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP: begin
              if (q_empty) begin
                out_load = 1'b1;
                out_d    = '{data_out: '0, status: STAT_EMPTY, last: 1'b1};
              end else begin
                mem_re = 1'b1;
                if (in_data_i.cmd == CMD_POP_FRONT) begin
                  mem_raddr = head_q;
                  head_d    = ptr_next(head_q);
                  occ_d     = occ_q - CntOne;
                  cnt_d     = CntOne;
                end else if (in_data_i.cmd == CMD_POP_BACK) begin
                  mem_raddr = ptr_prev(tail_q);
                  tail_d    = ptr_prev(tail_q);
                  occ_d     = occ_q - CntOne;
                  cnt_d     = CntOne;
                end else begin
                  // dump walks front to back, queue left as is
                  mem_raddr = head_q;
                  rptr_d    = ptr_next(head_q);
                  cnt_d     = occ_q;
                end
              end
            end
            default: ;  // unknown command: taken, no result
          endcase
        end
      end
      ST_READ: begin
        // move read data to the output, then fetch the next entry of a dump
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{data_out: $signed(32'(rd_data_q)),
                       status:   STAT_OK,
                       last:     (cnt_q == CntOne)};
          cnt_d    = cnt_q - CntOne;
          if (cnt_q != CntOne) begin
            mem_re    = 1'b1;
            mem_raddr = rptr_q;
            rptr_d    = ptr_next(rptr_q);
          end
        end
      end
      default: ;
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      cnt_q       <= '0;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      rptr_q      <= rptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `CDQ_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= CntFull)
  `CDQ_ASSERT_NOW(a_empty_ptrs, clk_i, rst_ni, q_empty, head_q == tail_q)
  `CDQ_ASSERT_NOW(a_read_pending, clk_i, rst_ni, state_q == ST_READ, cnt_q != '0)
  `CDQ_ASSERT_NEXT(a_pop_dec, clk_i, rst_ni,
                   in_fire && !q_empty && in_data_i.cmd == CMD_POP_FRONT,
                   occ_q == $past(occ_q) - CntOne)

endmodule
